>>> rtl/hps_pkg.sv
// Shared widths, codes, constants and the configuration type of the heading PID steering block.
package hps_pkg;

	localparam int YAW_W      = 16;
	localparam int ERR_W      = 17;
	localparam int COEF_W     = 16;
	localparam int OUT_W      = 48;
	localparam int SPEED_W    = 16;
	localparam int ACT_W      = 3;
	localparam int DB_W       = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Drive action codes
	localparam logic [ACT_W-1:0] ACT_RUN        = 3'd0;
	localparam logic [ACT_W-1:0] ACT_STOP       = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SPIN_RIGHT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SPIN_LEFT  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_TURN_RIGHT = 3'd4;
	localparam logic [ACT_W-1:0] ACT_TURN_LEFT  = 3'd5;
	localparam logic [ACT_W-1:0] ACT_NONE       = 3'd6;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_NOW       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV2     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_YAW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_BASE_SPEED = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND       = 3'd7;

	// Register reset values
	localparam logic [COEF_W-1:0]  RST_COEF_NOW       = 16'd2847;
	localparam logic [COEF_W-1:0]  RST_COEF_PREV      = 16'd4864;
	localparam logic [COEF_W-1:0]  RST_COEF_PREV2     = 16'd2048;
	localparam logic [SPEED_W-1:0] RST_RUN_BASE_SPEED = 16'd3700;
	localparam logic [DB_W-1:0]    RST_DEADBAND       = 15'd640;

	// Steering constants, angles in 1/128 degree
	localparam logic [SPEED_W-1:0]   TURN_BASE_SPEED  = 16'd3900;
	localparam logic [9:0]           SPEED_CAP        = 10'd1000;
	localparam logic signed [17:0]   WRAP_TARGET_EDGE = -18'sd22400;
	localparam logic signed [17:0]   WRAP_YAW_EDGE    = 18'sd15360;
	localparam logic signed [17:0]   FULL_TURN        = 18'sd46080;

	typedef struct packed {
		logic [COEF_W-1:0]  coef_now;
		logic [COEF_W-1:0]  coef_prev;
		logic [COEF_W-1:0]  coef_prev2;
		logic [YAW_W-1:0]   target_yaw;
		logic               run_mode;
		logic [SPEED_W-1:0] cruise_speed;
		logic [SPEED_W-1:0] run_base_speed;
		logic [DB_W-1:0]    deadband;
	} hps_cfg_t;

endpackage

>>> rtl/hps_ifs.sv
// Valid/ready channel interfaces for yaw samples and drive commands.
interface hps_in_if import hps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [YAW_W-1:0] measured_yaw;

	modport source (output valid, output measured_yaw, input ready);
	modport sink (input valid, input measured_yaw, output ready);
endinterface

interface hps_out_if import hps_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   drive_action;
	logic [SPEED_W-1:0] drive_speed;

	modport source (output valid, output drive_action, output drive_speed, input ready);
	modport sink (input valid, input drive_action, input drive_speed, output ready);
endinterface

>>> rtl/hps_cfg_regs.sv
// Configuration register file with its reset defaults.
module hps_cfg_regs import hps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output hps_cfg_t              cfg
);

	hps_cfg_t cfg_q;

	// Register writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_now       <= RST_COEF_NOW;
			cfg_q.coef_prev      <= RST_COEF_PREV;
			cfg_q.coef_prev2     <= RST_COEF_PREV2;
			cfg_q.target_yaw     <= '0;
			cfg_q.run_mode       <= 1'b0;
			cfg_q.cruise_speed   <= '0;
			cfg_q.run_base_speed <= RST_RUN_BASE_SPEED;
			cfg_q.deadband       <= RST_DEADBAND;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_NOW:       cfg_q.coef_now       <= cfg_data;
				REG_COEF_PREV:      cfg_q.coef_prev      <= cfg_data;
				REG_COEF_PREV2:     cfg_q.coef_prev2     <= cfg_data;
				REG_TARGET_YAW:     cfg_q.target_yaw     <= cfg_data;
				REG_RUN_MODE:       cfg_q.run_mode       <= cfg_data[0];
				REG_CRUISE_SPEED:   cfg_q.cruise_speed   <= cfg_data;
				REG_RUN_BASE_SPEED: cfg_q.run_base_speed <= cfg_data;
				REG_DEADBAND:       cfg_q.deadband       <= cfg_data[DB_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/hps_pid_core.sv
// Deadband test, yaw unwrap, incremental PID step and speed/direction selection.
module hps_pid_core import hps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [YAW_W-1:0]   yaw,
	input  hps_cfg_t           cfg,
	output logic [ACT_W-1:0]   action,
	output logic [SPEED_W-1:0] speed
);

	logic signed [ERR_W-1:0] last_error_q;
	logic signed [ERR_W-1:0] older_error_q;
	logic signed [OUT_W-1:0] last_output_q;

	logic signed [17:0] yaw_x, tgt_x, db_x, diff, yaw_u, err_x;
	logic signed [ERR_W-1:0] err;
	logic               on_heading, wrap;
	logic signed [33:0] p_now, p_prev, p_prev2;
	logic signed [49:0] sum;
	logic signed [OUT_W-1:0] sat;
	logic [OUT_W-1:0]   mag;
	logic [32:0]        mag_units;
	logic [9:0]         corr;
	logic [SPEED_W-1:0] base;
	logic [SPEED_W:0]   speed_sum;
	logic [SPEED_W-1:0] steer_speed;

	// Error forming, raw diff for the deadband and unwrapped err for the PID
	always_comb begin
		yaw_x      = {{2{yaw[YAW_W-1]}}, yaw};
		tgt_x      = {{2{cfg.target_yaw[YAW_W-1]}}, cfg.target_yaw};
		db_x       = {3'b000, cfg.deadband};
		diff       = yaw_x - tgt_x;
		on_heading = (diff > -db_x) && (diff < db_x);
		wrap       = (tgt_x < WRAP_TARGET_EDGE) && (yaw_x > WRAP_YAW_EDGE);
		yaw_u      = wrap ? (yaw_x - FULL_TURN) : yaw_x;
		err_x      = yaw_u - tgt_x;
		err        = err_x[ERR_W-1:0];
	end

	// Three products, Q.7 error by Q8.8 coefficient
	always_comb begin
		p_now   = $signed({1'b0, cfg.coef_now}) * err;
		p_prev  = $signed({1'b0, cfg.coef_prev}) * last_error_q;
		p_prev2 = $signed({1'b0, cfg.coef_prev2}) * older_error_q;
	end

	// Exact sum, saturated to 48 bits
	always_comb begin
		sum = {{2{last_output_q[OUT_W-1]}}, last_output_q}
			+ {{16{p_now[33]}}, p_now}
			- {{16{p_prev[33]}}, p_prev}
			+ {{16{p_prev2[33]}}, p_prev2};
		if (sum[49:47] == 3'b000 || sum[49:47] == 3'b111) begin
			sat = sum[OUT_W-1:0];
		end else if (sum[49]) begin
			sat = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

	// Speed: |out| in whole units, capped, plus base, saturated
	always_comb begin
		mag         = sat[OUT_W-1] ? (~sat + 48'd1) : sat;
		mag_units   = mag[OUT_W-1:15];
		corr        = (mag_units > {23'd0, SPEED_CAP}) ? SPEED_CAP : mag_units[9:0];
		base        = cfg.run_mode ? cfg.run_base_speed : TURN_BASE_SPEED;
		speed_sum   = {1'b0, base} + {7'd0, corr};
		steer_speed = speed_sum[SPEED_W] ? {SPEED_W{1'b1}} : speed_sum[SPEED_W-1:0];
	end

	// Command selection
	always_comb begin
		if (on_heading) begin
			action = cfg.run_mode ? ACT_RUN : ACT_STOP;
			speed  = cfg.run_mode ? cfg.cruise_speed : '0;
		end else if (err_x > db_x) begin
			action = cfg.run_mode ? ACT_TURN_RIGHT : ACT_SPIN_RIGHT;
			speed  = steer_speed;
		end else if (err_x < -db_x) begin
			action = cfg.run_mode ? ACT_TURN_LEFT : ACT_SPIN_LEFT;
			speed  = steer_speed;
		end else begin
			action = ACT_NONE;
			speed  = '0;
		end
	end

	// PID history, untouched inside the deadband
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q  <= '0;
			older_error_q <= '0;
			last_output_q <= '0;
		end else if (step && !on_heading) begin
			last_error_q  <= err;
			older_error_q <= last_error_q;
			last_output_q <= sat;
		end
	end

endmodule

>>> rtl/heading_pid_steering.sv
// Heading PID steering top level: input register, PID datapath, result register.
// An accepted item passes the input register and then the result register before its drive command is valid.
// Throughput: one item per cycle while the receiver keeps taking commands; the PID history updates as an item advances.
// The output register frees its slot in the same cycle the command is taken.
// Reset (arst_n low, async) clears both valid flags and the PID history and
// loads the register defaults; no clearing pass is needed.
module heading_pid_steering import hps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	hps_in_if.sink                in,
	hps_out_if.source             out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	hps_cfg_t           cfg;
	logic               valid_s1;
	logic [YAW_W-1:0]   yaw_s1;
	logic               out_valid_q;
	logic [ACT_W-1:0]   action_q;
	logic [SPEED_W-1:0] speed_q;
	logic [ACT_W-1:0]   action;
	logic [SPEED_W-1:0] speed;
	logic               out_free;
	logic               advance;

	hps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hps_pid_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.yaw    (yaw_s1),
		.cfg    (cfg),
		.action (action),
		.speed  (speed)
	);

	// Flow control
	assign out_free = !out_valid_q || out.ready;
	assign advance  = valid_s1 && out_free;
	assign in.ready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.ready && in.valid) begin
			yaw_s1 <= in.measured_yaw;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q <= action;
			speed_q  <= speed;
		end
	end

	assign out.valid        = out_valid_q;
	assign out.drive_action = action_q;
	assign out.drive_speed  = speed_q;

	// Checks
	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out.ready |-> !in.ready)
		else $error("input accepted while both stages are full and stalled");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in.valid && in.ready |=> valid_s1)
		else $error("accepted item lost before the datapath stage");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("computed command lost before the result register");

	a_idle_speed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (action_q == ACT_STOP || action_q == ACT_NONE) |-> speed_q == '0)
		else $error("nonzero speed on stop or none command");

endmodule

>>> tb/heading_pid_steering_tb.sv
// Self-checking testbench for the heading PID steering block.
module heading_pid_steering_tb;
	import hps_pkg::*;

	localparam longint OUT_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint OUT_LO = -OUT_HI - 1;

	typedef struct {
		logic [ACT_W-1:0]   action;
		logic [SPEED_W-1:0] speed;
	} drive_cmd_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hps_in_if  yaw_ch ();
	hps_out_if cmd_ch ();

	heading_pid_steering i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (yaw_ch),
		.out       (cmd_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register shadow and PID history of the steering predictor
	hps_cfg_t   cfg_copy;
	longint     pid_last_err;
	longint     pid_older_err;
	longint     pid_out;
	drive_cmd_t pending_cmds[$];

	int mismatch_count = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic void reset_model();
		cfg_copy = '{coef_now: RST_COEF_NOW, coef_prev: RST_COEF_PREV,
			coef_prev2: RST_COEF_PREV2, target_yaw: '0, run_mode: 1'b0,
			cruise_speed: '0, run_base_speed: RST_RUN_BASE_SPEED,
			deadband: RST_DEADBAND};
		pid_last_err = 0;
		pid_older_err = 0;
		pid_out = 0;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_COEF_NOW:       cfg_copy.coef_now = data;
			REG_COEF_PREV:      cfg_copy.coef_prev = data;
			REG_COEF_PREV2:     cfg_copy.coef_prev2 = data;
			REG_TARGET_YAW:     cfg_copy.target_yaw = data;
			REG_RUN_MODE:       cfg_copy.run_mode = data[0];
			REG_CRUISE_SPEED:   cfg_copy.cruise_speed = data;
			REG_RUN_BASE_SPEED: cfg_copy.run_base_speed = data;
			REG_DEADBAND:       cfg_copy.deadband = data[DB_W-1:0];
			default: ;
		endcase
	endfunction

	// Expected drive command for one yaw sample; advances the PID history
	function automatic drive_cmd_t steer_command(input logic [YAW_W-1:0] yaw_bits);
		longint     yaw, tgt, db, diff, err, sum, mag, spd;
		drive_cmd_t cmd;
		yaw = longint'($signed(yaw_bits));
		tgt = longint'($signed(cfg_copy.target_yaw));
		db = longint'(cfg_copy.deadband);
		diff = yaw - tgt;
		// on heading: run straight or stop, PID untouched
		if (diff > -db && diff < db) begin
			cmd.action = cfg_copy.run_mode ? ACT_RUN : ACT_STOP;
			cmd.speed = cfg_copy.run_mode ? cfg_copy.cruise_speed : '0;
			return cmd;
		end
		// unwrap around -180 degrees
		if (tgt < WRAP_TARGET_EDGE && yaw > WRAP_YAW_EDGE)
			yaw = yaw - FULL_TURN;
		err = yaw - tgt;
		sum = pid_out + longint'(cfg_copy.coef_now) * err
			- longint'(cfg_copy.coef_prev) * pid_last_err
			+ longint'(cfg_copy.coef_prev2) * pid_older_err;
		if (sum > OUT_HI)
			sum = OUT_HI;
		if (sum < OUT_LO)
			sum = OUT_LO;
		pid_out = sum;
		pid_older_err = pid_last_err;
		pid_last_err = err;
		// speed: truncated magnitude, capped, on top of the base
		mag = (sum < 0 ? -sum : sum) / 32768;
		if (mag > longint'(SPEED_CAP))
			mag = longint'(SPEED_CAP);
		spd = (cfg_copy.run_mode ? longint'(cfg_copy.run_base_speed)
			: longint'(TURN_BASE_SPEED)) + mag;
		if (spd > 65535)
			spd = 65535;
		cmd.speed = spd[SPEED_W-1:0];
		if (err > db) begin
			cmd.action = cfg_copy.run_mode ? ACT_TURN_RIGHT : ACT_SPIN_RIGHT;
		end else if (err < -db) begin
			cmd.action = cfg_copy.run_mode ? ACT_TURN_LEFT : ACT_SPIN_LEFT;
		end else begin
			cmd.action = ACT_NONE;
			cmd.speed = '0;
		end
		return cmd;
	endfunction

	// Register write; the enable stays up until close_writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic close_writes();
		cfg_we <= 1'b0;
	endtask

	// Offer one yaw item; each cycle ahead of it is idle with chance gap_pct
	task automatic send_yaw(input logic [YAW_W-1:0] yaw);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			yaw_ch.valid <= 1'b0;
			@(posedge clk);
		end
		yaw_ch.valid <= 1'b1;
		yaw_ch.measured_yaw <= yaw;
		@(posedge clk);
		while (!yaw_ch.ready)
			@(posedge clk);
		pending_cmds.push_back(steer_command(yaw));
	endtask

	// Stop offering and wait until every command has come back
	task automatic wait_commands_done();
		yaw_ch.valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_ch.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			cmd_ch.ready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			cmd_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare each taken command with the oldest expectation
	always @(posedge clk) begin : check_cmds
		drive_cmd_t want;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			if (pending_cmds.size() == 0) begin
				report_mismatch($sformatf("command with nothing expected: action %0d speed %0d",
					cmd_ch.drive_action, cmd_ch.drive_speed));
			end else begin
				want = pending_cmds.pop_front();
				if (cmd_ch.drive_action !== want.action)
					report_mismatch($sformatf("drive_action %0d, expected %0d",
						cmd_ch.drive_action, want.action));
				if (cmd_ch.drive_speed !== want.speed)
					report_mismatch($sformatf("drive_speed %0d, expected %0d",
						cmd_ch.drive_speed, want.speed));
			end
		end
	end

	function automatic logic [COEF_W-1:0] pick_coef(input bit full_range);
		int sel;
		sel = $urandom_range(99);
		if (sel < 10)
			return '0;
		if (full_range && sel < 25)
			return 16'hFFFF;
		if (full_range && sel < 60)
			return COEF_W'($urandom_range(65535));
		return COEF_W'($urandom_range(255));
	endfunction

	// Yaw samples biased toward the deadband edges and the wrap zone
	function automatic logic [YAW_W-1:0] pick_yaw();
		int     sel;
		longint tgt, db, v;
		sel = $urandom_range(99);
		tgt = longint'($signed(cfg_copy.target_yaw));
		db = longint'(cfg_copy.deadband);
		if (sel < 40) begin
			v = tgt + longint'($urandom_range(32'(6 * db + 16))) - 3 * db - 8;
		end else if (sel < 55) begin
			case ($urandom_range(5))
				0: v = tgt + db;
				1: v = tgt - db;
				2: v = tgt + db - 1;
				3: v = tgt - db + 1;
				4: v = tgt + db + 1;
				default: v = tgt - db - 1;
			endcase
		end else if (sel < 65) begin
			v = longint'($urandom_range(15350, 23040));
		end else begin
			v = longint'($urandom_range(65535));
		end
		return v[YAW_W-1:0];
	endfunction

	task automatic write_random_config(input bit full_range);
		int sel;
		logic [15:0] v;
		write_reg(REG_COEF_NOW, pick_coef(full_range));
		write_reg(REG_COEF_PREV, pick_coef(full_range));
		write_reg(REG_COEF_PREV2, pick_coef(full_range));
		sel = $urandom_range(99);
		if (sel < 10)
			v = -16'sd23040;
		else if (sel < 20)
			v = 16'sd23040;
		else if (sel < 30)
			v = $urandom_range(1) ? -16'sd22400 : -16'sd22401;
		else if (sel < 70)
			v = 16'($urandom_range(46080) - 23040);
		else
			v = 16'($urandom_range(65535));
		write_reg(REG_TARGET_YAW, v);
		write_reg(REG_RUN_MODE, 16'($urandom_range(65535)));
		write_reg(REG_CRUISE_SPEED, 16'($urandom_range(65535)));
		sel = $urandom_range(99);
		if (sel < 10)
			v = '0;
		else if (sel < 20)
			v = 16'd64535;
		else if (sel < 30)
			v = 16'hFFFF;
		else
			v = 16'($urandom_range(65535));
		write_reg(REG_RUN_BASE_SPEED, v);
		sel = $urandom_range(99);
		if (sel < 10)
			v = '0;
		else if (sel < 20)
			v = 16'd23040;
		else if (sel < 30)
			v = 16'd1;
		else if (sel < 80)
			v = 16'($urandom_range(1, 1500));
		else
			v = 16'($urandom_range(65535));
		write_reg(REG_DEADBAND, v);
		close_writes();
	endtask

	// Default registers: deadband edges and yaw extremes in stop mode
	task automatic test_reset_defaults();
		send_yaw(16'sd0);
		send_yaw(16'sd639);
		send_yaw(-16'sd639);
		send_yaw(16'sd640);
		send_yaw(-16'sd640);
		send_yaw(16'sd641);
		send_yaw(-16'sd641);
		send_yaw(16'h7FFF);
		send_yaw(16'h8000);
		wait_commands_done();
	endtask

	// Run mode: cruise inside the deadband, turns and speed overflow outside
	task automatic test_run_mode();
		write_reg(REG_RUN_MODE, 16'd1);
		write_reg(REG_CRUISE_SPEED, 16'hFFFF);
		write_reg(REG_RUN_BASE_SPEED, 16'hFFFF);
		close_writes();
		send_yaw(16'sd0);
		send_yaw(16'sd5000);
		send_yaw(-16'sd5000);
		wait_commands_done();
		write_reg(REG_CRUISE_SPEED, 16'd0);
		write_reg(REG_RUN_BASE_SPEED, 16'd0);
		close_writes();
		send_yaw(16'sd0);
		send_yaw(16'sd700);
		wait_commands_done();
	endtask

	// Unwrap near -180 degrees and its edges
	task automatic test_unwrap();
		write_reg(REG_RUN_MODE, 16'd0);
		write_reg(REG_TARGET_YAW, -16'sd23040);
		close_writes();
		send_yaw(16'sd23040);
		send_yaw(16'sd15361);
		send_yaw(16'sd15360);
		send_yaw(-16'sd23040);
		wait_commands_done();
		write_reg(REG_TARGET_YAW, -16'sd22400);
		close_writes();
		send_yaw(16'sd23040);
		wait_commands_done();
	endtask

	// Zero deadband: never on heading
	task automatic test_zero_deadband();
		write_reg(REG_TARGET_YAW, 16'sd0);
		write_reg(REG_DEADBAND, 16'd0);
		close_writes();
		send_yaw(16'sd0);
		send_yaw(16'sd1);
		send_yaw(-16'sd1);
		wait_commands_done();
	endtask

	// Coefficient extremes with small errors, then zero coefficients
	task automatic test_coef_extremes();
		write_reg(REG_DEADBAND, 16'd0);
		write_reg(REG_COEF_NOW, 16'hFFFF);
		write_reg(REG_COEF_PREV, 16'hFFFF);
		write_reg(REG_COEF_PREV2, 16'hFFFF);
		close_writes();
		send_yaw(-16'sd1);
		wait_commands_done();
		write_reg(REG_COEF_NOW, 16'd0);
		write_reg(REG_COEF_PREV, 16'd0);
		write_reg(REG_COEF_PREV2, 16'd0);
		write_reg(REG_DEADBAND, 16'd640);
		close_writes();
		send_yaw(16'sd1000);
		wait_commands_done();
	endtask

	// Long receiver hold-off while items keep coming: the block must stall
	task automatic test_backpressure();
		write_random_config(1'b0);
		gap_pct = 0;
		stall_pct = 0;
		hold_cycles = 60;
		repeat (20) send_yaw(pick_yaw());
		wait_commands_done();
	endtask

	// Random phases; idling pattern changes every two phases
	task automatic test_random_phases();
		for (int phase = 0; phase < 6; phase++) begin
			wait_commands_done();
			write_random_config(phase == 5);
			gap_pct = (phase < 2) ? 6 : (phase < 4) ? 88 : 0;
			stall_pct = (phase < 2) ? 88 : (phase < 4) ? 6 : 0;
			repeat (200) send_yaw(pick_yaw());
		end
		wait_commands_done();
	endtask

	// Drive the PID output far negative with the largest steps the inputs allow
	task automatic test_output_limit();
		gap_pct = 0;
		stall_pct = 0;
		write_reg(REG_COEF_NOW, 16'hFFFF);
		write_reg(REG_COEF_PREV, 16'd0);
		write_reg(REG_COEF_PREV2, 16'hFFFF);
		write_reg(REG_TARGET_YAW, 16'sd32767);
		write_reg(REG_RUN_MODE, 16'd1);
		write_reg(REG_DEADBAND, 16'd640);
		close_writes();
		repeat (250) send_yaw(16'h8000);
		wait_commands_done();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_COEF_NOW;
		cfg_data <= '0;
		yaw_ch.valid <= 1'b0;
		yaw_ch.measured_yaw <= '0;
		reset_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_run_mode();
		test_unwrap();
		test_zero_deadband();
		test_coef_extremes();
		test_backpressure();
		test_random_phases();
		test_output_limit();

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Run limit
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
